@@ sv/afp_pkg.sv @@
// ----------------------------------------------------------------------------
// afp_pkg: shared types and constants of the ascii integer field parser
// Character codes, phase and status codes, result and configuration structs,
// and the digit decode used by the parse step.
// ----------------------------------------------------------------------------
package afp_pkg;

    // width of the internal accumulator
    localparam int VALUE_BITS = 32;

    // depth of the result queue
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    // configuration register indexes
    localparam logic [1:0] CFG_RADIX  = 2'd0;
    localparam logic [1:0] CFG_SIGNED = 2'd1;
    localparam logic [1:0] CFG_WIDTH  = 2'd2;

    // radix_mode codes
    localparam logic [1:0] MODE_AUTO = 2'd0;
    localparam logic [1:0] MODE_OCT  = 2'd1;
    localparam logic [1:0] MODE_HEX  = 2'd2;

    // active radix codes
    localparam logic [1:0] RAD_DEC = 2'd0;
    localparam logic [1:0] RAD_OCT = 2'd1;
    localparam logic [1:0] RAD_HEX = 2'd2;

    // parse phases
    localparam logic [2:0] PH_SKIP   = 3'd0;
    localparam logic [2:0] PH_SIGNED = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_PREFIX = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NODIG = 2'd1;
    localparam logic [1:0] ST_END   = 2'd2;

    // characters
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [31:0] value;
        logic [7:0]  chars;
        logic [1:0]  status;
    } t_res;

    typedef struct packed {
        logic [1:0] radix_mode;
        logic       signed_mode;
        logic [7:0] max_width;
    } t_cfg;

    // digit value of c in the given radix; bit 4 set when it is a digit
    function automatic logic [4:0] digit_of(input logic [7:0] c, input logic [1:0] r);
        logic       ok;
        logic [7:0] d;
        logic [4:0] base;
        ok = 1'b1;
        d  = 8'd0;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30;
        end else if (c inside {[8'h61:8'h66]}) begin
            d = c - 8'h57;
        end else if (c inside {[8'h41:8'h46]}) begin
            d = c - 8'h37;
        end else begin
            ok = 1'b0;
        end
        base = (r == RAD_OCT) ? 5'd8 : ((r == RAD_HEX) ? 5'd16 : 5'd10);
        if (d[4:0] >= base) begin
            ok = 1'b0;
        end
        return {ok, d[3:0]};
    endfunction

endpackage

@@ sv/afp_step.sv @@
// ----------------------------------------------------------------------------
// afp_step: parse state and per-byte step logic
// Holds the field state and decides, for one byte or end marker, the next
// state and up to two results.
// ----------------------------------------------------------------------------
module afp_step import afp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,     // byte transaction taken this cycle
    input  logic [7:0] i_char,
    input  logic       i_end,
    input  t_cfg       i_cfg,
    output logic [1:0] o_res_n,     // number of results produced
    output t_res       o_res0,
    output t_res       o_res1
);

    typedef struct packed {
        logic       ok;
        logic [1:0] radix;
        logic [2:0] phase;
        logic [3:0] digit;
    } t_begin;

    logic [2:0]            r_phase, n_phase;
    logic [1:0]            r_radix, n_radix;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic                  r_neg, n_neg;
    logic [7:0]            r_cnt, n_cnt;

    logic [4:0]            dg, hexd;
    t_begin                bg;
    logic [7:0]            cnt_inc;
    logic [VALUE_BITS-1:0] scaled;
    logic                  ok, started, is_sign, is_ws;
    logic                  has_fin, has_extra;
    t_res                  fin, extra, fin_old;

    // first character after an optional sign
    function automatic t_begin try_begin(input logic [7:0] c, input logic [1:0] mode);
        t_begin     b;
        logic [1:0] sel;
        logic [4:0] d;
        sel = (mode == MODE_OCT) ? RAD_OCT : ((mode == MODE_HEX) ? RAD_HEX : RAD_DEC);
        d   = digit_of(c, sel);
        b   = '0;
        if (mode == MODE_OCT) begin
            b.ok    = d[4];
            b.radix = RAD_OCT;
            b.phase = PH_DIGITS;
            b.digit = d[3:0];
        end else if (c == CH_ZERO) begin
            b.ok    = 1'b1;
            b.radix = (mode == MODE_HEX) ? RAD_HEX : RAD_OCT;
            b.phase = PH_ZERO;
            b.digit = 4'd0;
        end else begin
            b.ok    = d[4];
            b.radix = sel;
            b.phase = PH_DIGITS;
            b.digit = d[3:0];
        end
        return b;
    endfunction

    // signed value truncated to the result width
    function automatic logic [31:0] val_out(input logic [VALUE_BITS-1:0] a, input logic n);
        logic [VALUE_BITS-1:0] v;
        v = n ? (~a + VALUE_BITS'(1)) : a;
        return 32'(v);
    endfunction

    // width limit check on a character count
    function automatic logic width_hit(input logic [7:0] cnt, input logic [7:0] mw);
        return (mw != 8'd0) && (cnt >= mw);
    endfunction

    // decode and accumulate
    always_comb begin
        n_phase   = r_phase;
        n_radix   = r_radix;
        n_acc     = r_acc;
        n_neg     = r_neg;
        n_cnt     = r_cnt;
        ok        = 1'b0;
        started   = 1'b0;
        has_fin   = 1'b0;
        has_extra = 1'b0;
        fin       = '0;
        extra     = '0;
        dg        = digit_of(i_char, r_radix);
        hexd      = digit_of(i_char, RAD_HEX);
        bg        = try_begin(i_char, i_cfg.radix_mode);
        cnt_inc   = (r_cnt == 8'hFF) ? r_cnt : r_cnt + 8'd1;
        is_sign   = (i_char == CH_PLUS) || ((i_char == CH_MINUS) && i_cfg.signed_mode);
        is_ws     = (i_char == CH_SPACE) || (i_char inside {[8'h09:8'h0D]});
        case (r_radix)
            RAD_OCT: scaled = r_acc << 3;
            RAD_HEX: scaled = r_acc << 4;
            default: scaled = (r_acc << 3) + (r_acc << 1);
        endcase
        fin_old.value  = (r_phase == PH_SIGNED) ? 32'd0 : val_out(r_acc, r_neg);
        fin_old.chars  = r_cnt;
        fin_old.status = (r_phase == PH_SIGNED) ? ST_NODIG : ST_OK;

        // extend the field under way
        if (r_phase != PH_SKIP && !i_end) begin
            case (r_phase)
                PH_SIGNED: begin
                    if (bg.ok) begin
                        ok      = 1'b1;
                        n_radix = bg.radix;
                        n_acc   = VALUE_BITS'(bg.digit);
                        n_phase = bg.phase;
                    end
                end
                PH_ZERO: begin
                    if (i_char == CH_UX || i_char == CH_LX) begin
                        ok      = 1'b1;
                        n_radix = RAD_HEX;
                        n_phase = PH_PREFIX;
                    end else if (dg[4]) begin
                        ok      = 1'b1;
                        n_acc   = VALUE_BITS'(dg[3:0]);
                        n_phase = PH_DIGITS;
                    end
                end
                PH_PREFIX: begin
                    if (hexd[4]) begin
                        ok      = 1'b1;
                        n_acc   = VALUE_BITS'(hexd[3:0]);
                        n_phase = PH_DIGITS;
                    end
                end
                PH_DIGITS: begin
                    if (dg[4]) begin
                        ok    = 1'b1;
                        n_acc = scaled + VALUE_BITS'(dg[3:0]);
                    end
                end
                default: ;
            endcase
        end

        if (ok) begin
            // byte extended the field; close it at the width limit
            n_cnt = cnt_inc;
            if (width_hit(cnt_inc, i_cfg.max_width)) begin
                has_fin      = 1'b1;
                fin.value    = val_out(n_acc, r_neg);
                fin.chars    = cnt_inc;
                fin.status   = ST_OK;
                n_phase      = PH_SKIP;
            end
        end else begin
            // close any field under way, then look at the byte as a new start
            if (r_phase != PH_SKIP) begin
                has_fin = 1'b1;
                fin     = fin_old;
                n_phase = PH_SKIP;
            end
            if (i_end) begin
                has_extra    = 1'b1;
                extra.status = ST_END;
            end else if (!is_ws) begin
                n_cnt = 8'd0;
                n_acc = '0;
                n_neg = 1'b0;
                if (is_sign) begin
                    started = 1'b1;
                    n_neg   = (i_char == CH_MINUS);
                    n_phase = PH_SIGNED;
                end else if (bg.ok) begin
                    started = 1'b1;
                    n_radix = bg.radix;
                    n_acc   = VALUE_BITS'(bg.digit);
                    n_phase = bg.phase;
                end else begin
                    has_extra    = 1'b1;
                    extra.chars  = 8'd1;
                    extra.status = ST_NODIG;
                end
                if (started) begin
                    n_cnt = 8'd1;
                    if (width_hit(8'd1, i_cfg.max_width)) begin
                        has_extra    = 1'b1;
                        extra.chars  = 8'd1;
                        extra.value  = is_sign ? 32'd0 : 32'(bg.digit);
                        extra.status = is_sign ? ST_NODIG : ST_OK;
                        n_phase      = PH_SKIP;
                    end
                end
            end
        end

        // pack results in order
        if (has_fin) begin
            o_res0  = fin;
            o_res1  = extra;
            o_res_n = has_extra ? 2'd2 : 2'd1;
        end else begin
            o_res0  = extra;
            o_res1  = '0;
            o_res_n = has_extra ? 2'd1 : 2'd0;
        end
    end

    // field state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_radix <= RAD_DEC;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_cnt   <= 8'd0;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_radix <= n_radix;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_cnt   <= n_cnt;
        end
    end

`ifndef SYNTHESIS
    // a second result comes from the byte itself: end report, stray byte or one-char field
    a_second_is_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_res_n == 2'd2 |-> o_res1.chars <= 8'd1)
        else $error("second result longer than one character");

    // a parsed field consumed at least one character
    a_ok_has_chars: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_res_n != 2'd0 && o_res0.status == ST_OK |-> o_res0.chars != 8'd0)
        else $error("parsed field with no characters");

    // end marker always leaves the parser between fields
    a_end_to_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_end |=> r_phase == PH_SKIP)
        else $error("field still open after end marker");

    // a pending sign is always the single character of its field
    a_sign_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SIGNED |-> r_cnt == 8'd1)
        else $error("sign phase with wrong character count");
`endif

endmodule

@@ sv/afp_res_fifo.sv @@
// ----------------------------------------------------------------------------
// afp_res_fifo: result queue
// Small register queue that takes up to two results per cycle and hands
// out one per output transaction.
// ----------------------------------------------------------------------------
module afp_res_fifo import afp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_n,
    input  t_res       i_res0,
    input  t_res       i_res1,
    input  logic       i_pop,
    output logic       o_valid,
    output t_res       o_res,
    output logic       o_room      // space for two more results
);

    t_res                r_mem [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] r_wp, n_wp;
    logic [RQ_PTR_W-1:0] r_rp, n_rp;
    logic [RQ_CNT_W-1:0] r_cnt, n_cnt;
    logic [RQ_PTR_W-1:0] wp1;

    assign wp1     = r_wp + RQ_PTR_W'(1);
    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rp];
    assign o_room  = (r_cnt <= RQ_CNT_W'(RQ_DEPTH - 2));

    // pointer and count update
    always_comb begin
        n_wp  = r_wp + RQ_PTR_W'(i_push_n);
        n_rp  = r_rp + RQ_PTR_W'(i_pop);
        n_cnt = r_cnt + RQ_CNT_W'(i_push_n) - RQ_CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wp] <= i_res0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[wp1] <= i_res1;
        end
    end

endmodule

@@ sv/ascii_integer_field_parser.sv @@
// ----------------------------------------------------------------------------
// ascii_integer_field_parser: integer fields from a character stream
// Skips white space, takes an optional sign and a radix prefix, and reports
// each integer field as a value, a character count and a status.
// ----------------------------------------------------------------------------
// The parser takes one character (or an end marker, tlast) per clock cycle
// and produces zero, one or two results for it; results leave through a
// four-entry register queue, which registers each result before it leaves.
// The input side stalls only while fewer than two queue entries are free,
// so with a consumer that takes a result every cycle the sustained rate is
// one character per cycle; a stream that makes two results for one
// character (such as an end marker inside a field) is bound by the
// one-result-per-cycle output. Configuration writes are always taken;
// radix and sign settings act from the start of the next field, and the
// width limit from the next character. There is no start-up sweep after
// reset.
module ascii_integer_field_parser import afp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // character stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_byte
    input  logic        i_s_tlast,   // end_of_input
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [31:0] value, [39:32] chars_used
    output logic [1:0]  o_m_tuser,   // [1:0] status
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    t_cfg       r_cfg;
    logic       in_take;
    logic       room;
    logic [1:0] res_n;
    t_res       res0, res1, res_out;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = room;
    assign in_take     = i_s_tvalid & room;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radix_mode  <= MODE_AUTO;
            r_cfg.signed_mode <= 1'b1;
            r_cfg.max_width   <= 8'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RADIX:  r_cfg.radix_mode  <= i_cfg_data[1:0];
                CFG_SIGNED: r_cfg.signed_mode <= i_cfg_data[0];
                CFG_WIDTH:  r_cfg.max_width   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // parse step
    afp_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_take),
        .i_char  (i_s_tdata),
        .i_end   (i_s_tlast),
        .i_cfg   (r_cfg),
        .o_res_n (res_n),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    // result queue
    afp_res_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (in_take ? res_n : 2'd0),
        .i_res0   (res0),
        .i_res1   (res1),
        .i_pop    (o_m_tvalid & i_m_tready),
        .o_valid  (o_m_tvalid),
        .o_res    (res_out),
        .o_room   (room)
    );

    assign o_m_tdata = {res_out.chars, res_out.value};
    assign o_m_tuser = res_out.status;

endmodule
